/* rtl/core/ttt_pkg.sv */
// ----------------------------------------------------------------------------
// Timed tag table package
// Shared types, field layout and codes for the timed tag table.
// ----------------------------------------------------------------------------
`default_nettype none

package ttt_pkg;

   // Request field widths and their packing in the data bus.
   localparam int unsigned IN_KEY_W   = 32;
   localparam int unsigned TIME_W     = 16;
   localparam int unsigned MODE_W     = 2;
   localparam int unsigned KEY_LSB    = 0;
   localparam int unsigned DUR_LSB    = 32;
   localparam int unsigned ALIVE_BIT  = 48;
   localparam int unsigned REQ_DATA_W = 56;
   localparam int unsigned RSP_DATA_W = 8;

   typedef enum logic [1:0] {
      MODE_TAG   = 2'd0,
      MODE_QUERY = 2'd1,
      MODE_TICK  = 2'd2,
      MODE_DROP  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_DONE     = 3'd0,
      ST_UPDATED  = 3'd1,
      ST_INSERTED = 3'd2,
      ST_FULL     = 3'd3,
      ST_IGNORED  = 3'd4
   } status_type;

   typedef struct packed {
      mode_type                 mode;
      logic [IN_KEY_W-1:0]      key;
      logic signed [TIME_W-1:0] duration;
      logic                     target_alive;
   } item_type;

   typedef struct packed {
      logic       tagged_now;
      status_type status;
   } result_type;

   // Per-slot verdict from the shared evaluation unit.
   typedef struct packed {
      logic              match;
      logic              live;
      logic              longer;
      logic              keep;
      logic [TIME_W-1:0] dec_time;
   } slot_eval_type;

endpackage

`default_nettype wire

/* rtl/core/timed_tag_table.sv */
// A tick, tag, query or drop request scans every slot of the table in turn,
// then passes the fix and finish states before its response is registered; a new request is
// taken only when the sequencer is idle again. The single memory read port visits one slot per cycle.
// A non-tick request with a zero key, or a tag on a dead target, skips the scan and is answered as ignored.
// Reset is synchronous; afterwards a clearing pass over every slot runs with req_tready low.
// ----------------------------------------------------------------------------
// Timed tag table
// Associative table of keys with signed remaining-time counts, one slot per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_tag_table #(
   parameter int unsigned TABLE_DEPTH = 32,
   parameter int unsigned KEY_WIDTH   = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // key [31:0], duration [47:32], target_alive [48], zero fill above
   input  wire logic [ttt_pkg::REQ_DATA_W-1:0]  req_tdata,
   // mode [1:0]
   input  wire logic [ttt_pkg::MODE_W-1:0]      req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // tagged_now [0], status [3:1], zero fill above
   output logic [ttt_pkg::RSP_DATA_W-1:0]       rsp_tdata
);

   import ttt_pkg::*;

   localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
   localparam int unsigned WORD_W = 1 + KEY_WIDTH + TIME_W;

   item_type             item;
   logic                 ctrl_idle;
   logic                 ctrl_done;
   result_type           ctrl_result;
   logic                 rsp_free;
   logic [ADDR_W-1:0]    rd_addr;
   logic [WORD_W-1:0]    rd_data;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [WORD_W-1:0]    wr_data;
   logic [KEY_WIDTH-1:0] eval_key;
   logic [TIME_W-1:0]    eval_duration;
   slot_eval_type        verdict;

   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_ff,       rsp_in;

   // Unpack the request.
   always_comb begin
      item.mode         = mode_type'(req_tuser);
      item.key          = req_tdata[KEY_LSB +: IN_KEY_W];
      item.duration     = req_tdata[DUR_LSB +: TIME_W];
      item.target_alive = req_tdata[ALIVE_BIT];
   end

   assign req_tready = ctrl_idle;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   ttt_mem #(
      .DEPTH  (TABLE_DEPTH),
      .WIDTH  (WORD_W),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ttt_slot_eval #(
      .KEY_WIDTH (KEY_WIDTH),
      .WORD_W    (WORD_W)
   ) u_eval (
      .word          (rd_data),
      .item_key      (eval_key),
      .item_duration (eval_duration),
      .verdict       (verdict)
   );

   ttt_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_WIDTH   (KEY_WIDTH),
      .ADDR_W      (ADDR_W),
      .WORD_W      (WORD_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (req_tvalid && req_tready),
      .item          (item),
      .rsp_free      (rsp_free),
      .idle          (ctrl_idle),
      .done          (ctrl_done),
      .result        (ctrl_result),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .verdict       (verdict),
      .eval_key      (eval_key),
      .eval_duration (eval_duration),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data)
   );

   // Response output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (ctrl_done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = ctrl_result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_ff.status, rsp_ff.tagged_now});

endmodule

`default_nettype wire

/* rtl/core/ttt_mem.sv */
// ----------------------------------------------------------------------------
// Timed tag table slot memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ttt_mem #(
   parameter int unsigned DEPTH  = 32,
   parameter int unsigned WIDTH  = 49,
   parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* rtl/core/ttt_slot_eval.sv */
// ----------------------------------------------------------------------------
// Timed tag table slot evaluation unit
// Key compare, time compare and tick decrement for the slot being scanned.
// ----------------------------------------------------------------------------
`default_nettype none

module ttt_slot_eval #(
   parameter int unsigned KEY_WIDTH = 32,
   parameter int unsigned WORD_W    = 1 + KEY_WIDTH + ttt_pkg::TIME_W
) (
   input  wire logic [WORD_W-1:0]            word,
   input  wire logic [KEY_WIDTH-1:0]         item_key,
   input  wire logic [ttt_pkg::TIME_W-1:0]   item_duration,
   output ttt_pkg::slot_eval_type            verdict
);

   import ttt_pkg::*;

   logic                     slot_valid;
   logic [KEY_WIDTH-1:0]     slot_key;
   logic signed [TIME_W-1:0] slot_time;
   logic signed [TIME_W-1:0] dur_s;
   logic signed [TIME_W:0]   dec;

   // Unpack the slot word: valid on top, then key, time in the low bits.
   assign slot_valid = word[WORD_W-1];
   assign slot_key   = word[TIME_W +: KEY_WIDTH];
   assign slot_time  = word[TIME_W-1:0];
   assign dur_s      = item_duration;

   // Decrement one bit wider so the most negative time does not wrap.
   assign dec = {slot_time[TIME_W-1], slot_time} - (TIME_W+1)'(1);

   always_comb begin
      verdict.match    = slot_valid && (slot_key == item_key);
      verdict.live     = verdict.match && (slot_time > $signed(TIME_W'(0)));
      verdict.longer   = dur_s > slot_time;
      verdict.keep     = slot_valid && !dec[TIME_W] && (dec != '0);
      verdict.dec_time = dec[TIME_W-1:0];
   end

endmodule

`default_nettype wire

/* rtl/core/ttt_ctrl.sv */
// ----------------------------------------------------------------------------
// Timed tag table sequencer
// Clears the table after reset, then scans every slot once per request that is not ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module ttt_ctrl #(
   parameter int unsigned TABLE_DEPTH = 32,
   parameter int unsigned KEY_WIDTH   = 32,
   parameter int unsigned ADDR_W      = $clog2(TABLE_DEPTH),
   parameter int unsigned WORD_W      = 1 + KEY_WIDTH + ttt_pkg::TIME_W
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire ttt_pkg::item_type          item,
   input  wire logic                       rsp_free,
   output logic                            idle,
   output logic                            done,
   output ttt_pkg::result_type             result,
   output logic [ADDR_W-1:0]               rd_addr,
   input  wire logic [WORD_W-1:0]          rd_data,
   input  wire ttt_pkg::slot_eval_type     verdict,
   output logic [KEY_WIDTH-1:0]            eval_key,
   output logic [ttt_pkg::TIME_W-1:0]      eval_duration,
   output logic                            wr_en,
   output logic [ADDR_W-1:0]               wr_addr,
   output logic [WORD_W-1:0]               wr_data
);

   import ttt_pkg::*;

   localparam int unsigned CNT_W    = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned KEY_IN_W = (KEY_WIDTH < IN_KEY_W) ? KEY_WIDTH : IN_KEY_W;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_FIX,
      S_FINISH
   } state_type;

   state_type                 state_ff,      state_in;
   logic [CNT_W-1:0]          cnt_ff,        cnt_in;
   logic                      proc_vld_ff,   proc_vld_in;
   logic [ADDR_W-1:0]         proc_idx_ff,   proc_idx_in;
   mode_type                  mode_ff,       mode_in;
   logic [KEY_WIDTH-1:0]      key_ff,        key_in;
   logic [TIME_W-1:0]         dur_ff,        dur_in;
   logic                      hit_found_ff,  hit_found_in;
   logic [ADDR_W-1:0]         hit_idx_ff,    hit_idx_in;
   logic                      hit_longer_ff, hit_longer_in;
   logic                      free_found_ff, free_found_in;
   logic [ADDR_W-1:0]         free_idx_ff,   free_idx_in;
   logic                      tagged_ff,     tagged_in;
   status_type                status_ff,     status_in;

   logic [KEY_WIDTH-1:0]      key_eff;
   logic                      scan_end;

   // Only the low key bits that fit the table take part.
   always_comb begin
      key_eff = '0;
      key_eff[KEY_IN_W-1:0] = item.key[KEY_IN_W-1:0];
   end

   assign scan_end = (cnt_ff == CNT_W'(TABLE_DEPTH));

   // Read address walks the slots; held at zero once the scan count is spent.
   assign rd_addr = scan_end ? '0 : cnt_ff[ADDR_W-1:0];

   assign eval_key      = key_ff;
   assign eval_duration = dur_ff;

   assign idle   = (state_ff == S_IDLE);
   assign done   = (state_ff == S_FINISH) && rsp_free;
   assign result = '{tagged_now: tagged_ff, status: status_ff};

   // Memory write port: clearing pass, per-slot write-back, final tag write.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = proc_idx_ff;
      wr_data = {1'b0, rd_data[WORD_W-2:0]};
      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff[ADDR_W-1:0];
            wr_data = '0;
         end
         S_SCAN: begin
            if (proc_vld_ff && mode_ff == MODE_TICK) begin
               wr_en   = rd_data[WORD_W-1];
               wr_data = {verdict.keep, rd_data[TIME_W +: KEY_WIDTH], verdict.dec_time};
            end else if (proc_vld_ff && mode_ff == MODE_DROP) begin
               wr_en = verdict.match;
            end
         end
         S_FIX: begin
            wr_data = {1'b1, key_ff, dur_ff};
            if (mode_ff == MODE_TAG) begin
               if (hit_found_ff) begin
                  wr_en   = hit_longer_ff;
                  wr_addr = hit_idx_ff;
               end else begin
                  wr_en   = free_found_ff;
                  wr_addr = free_idx_ff;
               end
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // Sequencer next-state logic.
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      proc_vld_in   = 1'b0;
      proc_idx_in   = rd_addr;
      mode_in       = mode_ff;
      key_in        = key_ff;
      dur_in        = dur_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_longer_in = hit_longer_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      tagged_in     = tagged_ff;
      status_in     = status_ff;
      case (state_ff)
         S_CLEAR: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(TABLE_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               mode_in       = item.mode;
               key_in        = key_eff;
               dur_in        = item.duration;
               cnt_in        = '0;
               hit_found_in  = 1'b0;
               free_found_in = 1'b0;
               hit_longer_in = 1'b0;
               tagged_in     = 1'b0;
               status_in     = ST_DONE;
               // A zero key outside a tick, or a tag on a dead target, skips the scan.
               if ((item.mode != MODE_TICK && key_eff == '0) ||
                   (item.mode == MODE_TAG && !item.target_alive)) begin
                  status_in = ST_IGNORED;
                  state_in  = S_FINISH;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            proc_vld_in = !scan_end;
            if (!scan_end) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            if (proc_vld_ff) begin
               if (mode_ff == MODE_QUERY && verdict.live) begin
                  tagged_in = 1'b1;
               end
               // Tags remember the first matching slot and the first free slot.
               if (mode_ff == MODE_TAG) begin
                  if (verdict.match && !hit_found_ff) begin
                     hit_found_in  = 1'b1;
                     hit_idx_in    = proc_idx_ff;
                     hit_longer_in = verdict.longer;
                  end
                  if (!rd_data[WORD_W-1] && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_idx_in   = proc_idx_ff;
                  end
               end
            end
            if (scan_end) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            if (mode_ff == MODE_TAG) begin
               if (hit_found_ff) begin
                  status_in = ST_UPDATED;
               end else if (free_found_ff) begin
                  status_in = ST_INSERTED;
               end else begin
                  status_in = ST_FULL;
               end
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         cnt_ff      <= '0;
         proc_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         proc_vld_ff <= proc_vld_in;
      end
   end

   // Request and scan payload registers.
   always_ff @(posedge clock) begin
      proc_idx_ff   <= proc_idx_in;
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      dur_ff        <= dur_in;
      hit_found_ff  <= hit_found_in;
      hit_idx_ff    <= hit_idx_in;
      hit_longer_ff <= hit_longer_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      tagged_ff     <= tagged_in;
      status_ff     <= status_in;
   end

endmodule

`default_nettype wire
